// ===== rtl/lkv_pkg.sv =====
// Shared constants for the LRU key/value cache: field widths, item kinds,
// reset and miss values. No dependencies.
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int KEY_W           = 32;
    localparam int VALUE_W         = 32;
    localparam int CAP_W           = 5;
    localparam int ENTRIES_DEFAULT = 16;

    localparam logic             KIND_GET       = 1'b0;
    localparam logic             KIND_PUT       = 1'b1;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
    localparam logic [VALUE_W-1:0] MISS_VALUE   = {VALUE_W{1'b1}};

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key/value cache: input register,
// store with recency ranks, and result register. Depends on lkv_pkg, lkv_lookup.
`timescale 1ns / 1ps

// Latency: a get's result is registered twice, in the input register and then
// in the result register. Puts produce no result.
// Throughput: one item per cycle while the result side does not stall gets; the
// key match and rank update over all entries are combinational.
// Reset (synchronous, aresetn low): the store empties (all entries invalid,
// count zero, ranks zero) at once, capacity returns to 16; keys and values
// are not cleared and are only read from valid entries.
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration: capacity_in_use.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]          cfg_data,
    // Input items.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_kind,
    input  logic signed [lkv_pkg::KEY_W-1:0]   s_lookup_key,
    input  logic signed [lkv_pkg::VALUE_W-1:0] s_put_value,
    // Result items, one per get.
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_found,
    output logic signed [lkv_pkg::VALUE_W-1:0] m_read_value
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // Configuration register.
    logic [lkv_pkg::CAP_W-1:0] capacity_reg;

    // Input register.
    logic                        in_valid_reg;
    logic                        in_kind_reg;
    logic [lkv_pkg::KEY_W-1:0]   in_key_reg;
    logic [lkv_pkg::VALUE_W-1:0] in_value_reg;

    // Store. Keys and values are plain registers without reset; the valid
    // bits and ranks are control state.
    logic [lkv_pkg::KEY_W-1:0]   key_reg   [ENTRIES];
    logic [lkv_pkg::VALUE_W-1:0] value_reg [ENTRIES];
    logic [ENTRIES-1:0]          valid_reg, valid_next;
    logic [IW-1:0]               rank_reg  [ENTRIES];
    logic [IW-1:0]               rank_next [ENTRIES];
    logic [CW-1:0]               count_reg, count_next;

    // Result register.
    logic                        m_valid_reg;
    logic                        m_found_reg;
    logic [lkv_pkg::VALUE_W-1:0] m_value_reg;

    // Lookup results.
    logic          hit;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] free_idx;
    logic [IW-1:0] lru_idx;

    // Update controls.
    logic          advance;
    logic          write_key;
    logic          write_value;
    logic [IW-1:0] slot;
    logic [IW-1:0] touch_rank;
    logic [7:0]    eff_capacity;

    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_read_value = m_value_reg;

    // The held item moves on when it is a put, or when the result register
    // is free or its result is being transferred in this cycle.
    assign advance = in_valid_reg &&
                     (in_kind_reg == lkv_pkg::KIND_PUT || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // A capacity of zero acts as one; a capacity above the depth saturates.
    always_comb begin
        eff_capacity = 8'(capacity_reg);
        if (capacity_reg == '0) begin
            eff_capacity = 8'd1;
        end else if (8'(capacity_reg) > 8'(ENTRIES)) begin
            eff_capacity = 8'(ENTRIES);
        end
    end

    lkv_lookup #(
        .ENTRIES (ENTRIES),
        .IW      (IW),
        .CW      (CW)
    ) u_lookup (
        .keys     (key_reg),
        .valid    (valid_reg),
        .ranks    (rank_reg),
        .count    (count_reg),
        .key      (in_key_reg),
        .hit      (hit),
        .hit_idx  (hit_idx),
        .free_idx (free_idx),
        .lru_idx  (lru_idx)
    );

    // Choose the slot the item touches and the rank it held. Entries that
    // were newer than that rank age by one, and the slot becomes rank zero.
    // A new entry in a free slot enters at rank count, below every other
    // valid entry, so all of them age; an eviction reuses the oldest rank.
    always_comb begin
        valid_next  = valid_reg;
        rank_next   = rank_reg;
        count_next  = count_reg;
        write_key   = 1'b0;
        write_value = 1'b0;
        slot        = hit_idx;
        touch_rank  = rank_reg[hit_idx];
        if (advance && (hit || in_kind_reg == lkv_pkg::KIND_PUT)) begin
            if (in_kind_reg == lkv_pkg::KIND_PUT) begin
                write_value = 1'b1;
                if (!hit) begin
                    write_key = 1'b1;
                    if (8'(count_reg) < eff_capacity) begin
                        slot             = free_idx;
                        touch_rank       = IW'(count_reg);
                        valid_next[free_idx] = 1'b1;
                        count_next       = count_reg + CW'(1);
                    end else begin
                        slot       = lru_idx;
                        touch_rank = IW'(count_reg - CW'(1));
                    end
                end
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (valid_next[i] && IW'(i) != slot && rank_reg[i] < touch_rank) begin
                    rank_next[i] = rank_reg[i] + IW'(1);
                end
            end
            rank_next[slot] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lkv_pkg::CAPACITY_RESET;
            in_valid_reg <= 1'b0;
            valid_reg    <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
            if (advance && in_kind_reg == lkv_pkg::KIND_GET) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: input item, stored keys and values, result fields.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg  <= s_kind;
            in_key_reg   <= s_lookup_key;
            in_value_reg <= s_put_value;
        end
        if (write_key) begin
            key_reg[slot] <= in_key_reg;
        end
        if (write_value) begin
            value_reg[slot] <= in_value_reg;
        end
        if (advance && in_kind_reg == lkv_pkg::KIND_GET) begin
            m_found_reg <= hit;
            m_value_reg <= hit ? value_reg[hit_idx] : lkv_pkg::MISS_VALUE;
        end
    end

endmodule

// ===== rtl/lkv_lookup.sv =====
// Parallel key match, free slot search and LRU slot selection over the store.
// Depends on lkv_pkg for the key width.
`timescale 1ns / 1ps

module lkv_lookup #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT,
    parameter int IW      = $clog2(ENTRIES),
    parameter int CW      = $clog2(ENTRIES + 1)
) (
    input  logic [lkv_pkg::KEY_W-1:0] keys [ENTRIES],
    input  logic [ENTRIES-1:0]        valid,
    input  logic [IW-1:0]             ranks [ENTRIES],
    input  logic [CW-1:0]             count,
    input  logic [lkv_pkg::KEY_W-1:0] key,
    output logic                      hit,
    output logic [IW-1:0]             hit_idx,
    output logic [IW-1:0]             free_idx,
    output logic [IW-1:0]             lru_idx
);

    logic [IW-1:0] lru_rank;

    assign lru_rank = IW'(count - CW'(1));

    // Valid keys are unique, so at most one entry matches. The lowest free
    // slot wins; the LRU entry is the valid one holding the oldest rank.
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (valid[i] && keys[i] == key) begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid[i]) begin
                free_idx = IW'(i);
            end
            if (valid[i] && ranks[i] == lru_rank) begin
                lru_idx = IW'(i);
            end
        end
    end

endmodule

// ===== sim/lru_key_value_cache_test.sv =====
// Self-checking testbench for lru_key_value_cache: directed and random get/put
// traffic against a cycle-free LRU store model kept in a small scoreboard class.
// Depends on lkv_pkg and lru_key_value_cache.
`timescale 1ns / 1ps

module lru_key_value_cache_test;

    localparam int CACHE_ENTRIES    = lkv_pkg::ENTRIES_DEFAULT;
    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 7;
    localparam int SETTLE_CYCLES    = 4;      // result register latency plus margin
    localparam int LONG_HOLD_CYCLES = 100;
    localparam int PHASE_ITEMS      = 120;
    localparam int RUN_LIMIT_NS     = 4_000_000;

    typedef logic [lkv_pkg::CAP_W-1:0] cap_t;

    typedef struct packed {
        logic                        found;
        logic [lkv_pkg::VALUE_W-1:0] value;
    } lookup_result_t;

    typedef enum {SINK_ALWAYS, SINK_SPARSE, SINK_SQUARE, SINK_COIN} sink_mode_t;

    // LRU store model plus the queue of lookup results still owed by the block.
    class lru_store_model;
        logic [lkv_pkg::KEY_W-1:0]   key_of   [CACHE_ENTRIES];
        logic [lkv_pkg::VALUE_W-1:0] value_of [CACHE_ENTRIES];
        bit                          live     [CACHE_ENTRIES];
        int unsigned                 age      [CACHE_ENTRIES];
        int unsigned                 held;
        logic [lkv_pkg::CAP_W-1:0]   capacity;
        lookup_result_t              lookups_due[$];
        int                          mismatches;

        function new();
            foreach (live[i]) begin
                live[i] = 1'b0;
                age[i]  = 0;
            end
            held       = 0;
            capacity   = lkv_pkg::CAPACITY_RESET;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        function int pending();
            return lookups_due.size();
        endfunction

        function int unsigned usable_slots();
            if (capacity == 0)
                return 1;
            if (capacity > CACHE_ENTRIES)
                return CACHE_ENTRIES;
            return 32'(capacity);
        endfunction

        // Entries that were more recent than slot s age by one; s becomes newest.
        function void promote(int s);
            int unsigned r;
            r = age[s];
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                if (live[i] && i != s && age[i] < r)
                    age[i]++;
            end
            age[s] = 0;
        endfunction

        function void note_item(logic kind, logic [lkv_pkg::KEY_W-1:0] key,
                                logic [lkv_pkg::VALUE_W-1:0] value);
            int             slot;
            lookup_result_t due;
            slot = -1;
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                if (slot < 0 && live[i] && key_of[i] == key)
                    slot = i;
            end
            if (kind == lkv_pkg::KIND_GET) begin
                if (slot >= 0) begin
                    promote(slot);
                    due.found = 1'b1;
                    due.value = value_of[slot];
                end else begin
                    due.found = 1'b0;
                    due.value = lkv_pkg::MISS_VALUE;
                end
                lookups_due.push_back(due);
            end else begin
                if (slot < 0) begin
                    if (held < usable_slots()) begin
                        // Lowest free slot, entering as the least recent entry.
                        for (int i = 0; i < CACHE_ENTRIES; i++) begin
                            if (slot < 0 && !live[i])
                                slot = i;
                        end
                        live[slot] = 1'b1;
                        age[slot]  = held;
                        held++;
                    end else begin
                        for (int i = 0; i < CACHE_ENTRIES; i++) begin
                            if (live[i] && (slot < 0 || age[i] >= age[slot]))
                                slot = i;
                        end
                    end
                    key_of[slot] = key;
                end
                value_of[slot] = value;
                promote(slot);
            end
        endfunction

        function void check_lookup(logic found, logic [lkv_pkg::VALUE_W-1:0] value);
            lookup_result_t due;
            if (lookups_due.size() == 0) begin
                $display("%0t: unexpected result: found %0b read_value %h", $time, found, value);
                mismatches++;
                return;
            end
            due = lookups_due.pop_front();
            if (found !== due.found) begin
                $display("%0t: found mismatch: expected %0b actual %0b",
                         $time, due.found, found);
                mismatches++;
            end
            if (value !== due.value) begin
                $display("%0t: read_value mismatch: expected %h actual %h",
                         $time, due.value, value);
                mismatches++;
            end
        endfunction
    endclass

    logic                               aclk         = 1'b0;
    logic                               aresetn      = 1'b0;
    logic                               cfg_valid    = 1'b0;
    logic                               cfg_ready;
    logic [lkv_pkg::CAP_W-1:0]          cfg_data     = '0;
    logic                               s_valid      = 1'b0;
    logic                               s_ready;
    logic                               s_kind       = lkv_pkg::KIND_GET;
    logic signed [lkv_pkg::KEY_W-1:0]   s_lookup_key = '0;
    logic signed [lkv_pkg::VALUE_W-1:0] s_put_value  = '0;
    logic                               m_valid;
    logic                               m_ready      = 1'b0;
    logic                               m_found;
    logic signed [lkv_pkg::VALUE_W-1:0] m_read_value;

    lru_store_model cache_sb;
    int             burst_left = 0;
    bit             full_rate  = 1'b0;
    int             hold_asked = 0;
    int             hold_done  = 0;

    lru_key_value_cache #(
        .ENTRIES(CACHE_ENTRIES)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_lookup_key(s_lookup_key),
        .s_put_value (s_put_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_found     (m_found),
        .m_read_value(m_read_value)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic pace();
        int gap;
        if (!full_rate) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, 6);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
                burst_left = $urandom_range(0, 24);
            end
        end
    endtask

    task automatic send_item(input logic kind, input logic [lkv_pkg::KEY_W-1:0] key,
                             input logic [lkv_pkg::VALUE_W-1:0] value);
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_lookup_key <= key;
        s_put_value  <= value;
        do @(posedge aclk); while (!s_ready);
        cache_sb.note_item(kind, key, value);
        pace();
    endtask

    // Stop sending and wait until every lookup result has been returned.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (cache_sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cache_sb.set_capacity(cap);
    endtask

    task automatic directed_items();
        send_item(lkv_pkg::KIND_GET, 32'h0000_0000, 32'h0000_0000);   // empty store misses
        send_item(lkv_pkg::KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
        send_item(lkv_pkg::KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
        send_item(lkv_pkg::KIND_PUT, 32'h0000_0000, 32'hffff_ffff);
        send_item(lkv_pkg::KIND_PUT, 32'hffff_ffff, 32'h0000_0000);
        send_item(lkv_pkg::KIND_GET, 32'h8000_0000, 32'hffff_ffff);   // value is ignored on a get
        send_item(lkv_pkg::KIND_GET, 32'h7fff_ffff, 32'h0000_0000);
        send_item(lkv_pkg::KIND_GET, 32'h0000_0000, 32'h0000_0000);   // hit on a stored all-ones
        send_item(lkv_pkg::KIND_GET, 32'hffff_ffff, 32'h0000_0000);
        send_item(lkv_pkg::KIND_PUT, 32'h0000_0000, 32'h1234_5678);   // overwrite of a present key
        send_item(lkv_pkg::KIND_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(lkv_pkg::KIND_GET, 32'h0000_0001, 32'h0000_0000);
        // Capacity zero acts as one, and it is now below the four entries held.
        write_capacity(5'd0);
        send_item(lkv_pkg::KIND_PUT, 32'h5555_5555, 32'haaaa_aaaa);
        send_item(lkv_pkg::KIND_GET, 32'h8000_0000, 32'h0000_0000);   // evicted as least recent
        send_item(lkv_pkg::KIND_GET, 32'h5555_5555, 32'h0000_0000);
        send_item(lkv_pkg::KIND_GET, 32'h7fff_ffff, 32'h0000_0000);
        // Capacity above the entry count saturates to the full store.
        write_capacity(5'd31);
        send_item(lkv_pkg::KIND_PUT, 32'haaaa_aaaa, 32'h5555_5555);
        send_item(lkv_pkg::KIND_PUT, 32'h0000_0001, 32'h0000_0001);
        send_item(lkv_pkg::KIND_GET, 32'haaaa_aaaa, 32'h0000_0000);
        send_item(lkv_pkg::KIND_GET, 32'h0000_0001, 32'h0000_0000);
        send_item(lkv_pkg::KIND_GET, 32'h5555_5555, 32'h0000_0000);
    endtask

    // One capacity setting, then random traffic over a key set a little larger
    // than the capacity so that hits, updates and evictions all occur.
    task automatic random_phase(input logic [lkv_pkg::CAP_W-1:0] cap, input bit pressure);
        logic [lkv_pkg::KEY_W-1:0]   key_set[$];
        logic [lkv_pkg::KEY_W-1:0]   key;
        logic [lkv_pkg::VALUE_W-1:0] value;
        logic                        kind;
        int                          usable;
        int                          set_size;
        write_capacity(cap);
        usable   = (cap == 0) ? 1 : ((cap > CACHE_ENTRIES) ? CACHE_ENTRIES : cap);
        set_size = usable + $urandom_range(1, 6);
        repeat (set_size) key_set.push_back($urandom());
        if ($urandom_range(0, 1)) begin
            key_set[0] = 32'h8000_0000;
            key_set[1] = 32'h7fff_ffff;
        end
        full_rate = pressure || ($urandom_range(0, 4) == 0);
        if (pressure)
            hold_asked++;
        repeat (PHASE_ITEMS) begin
            kind = $urandom_range(0, 1) ? lkv_pkg::KIND_PUT : lkv_pkg::KIND_GET;
            if ($urandom_range(0, 9) == 0)
                key = $urandom();
            else
                key = key_set[$urandom_range(0, key_set.size() - 1)];
            case ($urandom_range(0, 15))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7fff_ffff;
                2:       value = '1;
                3:       value = '0;
                default: value = $urandom();
            endcase
            send_item(kind, key, value);
        end
        full_rate = 1'b0;
    endtask

    initial begin : stimulus
        logic [lkv_pkg::CAP_W-1:0] phase_caps[$];
        phase_caps = '{5'd16, 5'd1, 5'd2, 5'd3, 5'd5, 5'd8, 5'd0, 5'd17, 5'd31, 5'd4, 5'd12, 5'd0};
        phase_caps[phase_caps.size() - 1] = cap_t'($urandom_range(0, 31));
        cache_sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_items();
        foreach (phase_caps[p])
            random_phase(phase_caps[p], p == 2);
        drain();
        if (cache_sb.mismatches == 0 && cache_sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: mostly a changing stall pattern, plus one long hold-off on
    // request so that the block backs up and stalls its input.
    initial begin : result_sink
        sink_mode_t mode;
        int         cycle_count;
        mode        = SINK_ALWAYS;
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            if (hold_done < hold_asked) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_done++;
            end else begin
                if (cycle_count % 97 == 0)
                    mode = sink_mode_t'($urandom_range(0, 3));
                cycle_count++;
                case (mode)
                    SINK_ALWAYS: m_ready <= 1'b1;
                    SINK_SPARSE: m_ready <= ($urandom_range(0, 3) != 0);
                    SINK_SQUARE: m_ready <= cycle_count[2];
                    default:     m_ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            cache_sb.check_lookup(m_found, m_read_value);
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
